// File: sv/hrdp_pkg.sv
`timescale 1ns / 1ps

package hrdp_pkg;

   // Long item prefix
   localparam logic [7:0] LONG_PREFIX = 8'hfe;

   // Item types, prefix bits 3..2
   localparam logic [1:0] ITEM_MAIN   = 2'b00;
   localparam logic [1:0] ITEM_GLOBAL = 2'b01;
   localparam logic [1:0] ITEM_LOCAL  = 2'b10;

   // Item tags, prefix bits 7..2
   localparam logic [5:0] TAG_USAGE_PAGE   = 6'h01;
   localparam logic [5:0] TAG_LOGICAL_MIN  = 6'h05;
   localparam logic [5:0] TAG_LOGICAL_MAX  = 6'h09;
   localparam logic [5:0] TAG_REPORT_SIZE  = 6'h1d;
   localparam logic [5:0] TAG_REPORT_ID    = 6'h21;
   localparam logic [5:0] TAG_REPORT_COUNT = 6'h25;
   localparam logic [5:0] TAG_PUSH         = 6'h29;
   localparam logic [5:0] TAG_POP          = 6'h2d;
   localparam logic [5:0] TAG_USAGE        = 6'h02;
   localparam logic [5:0] TAG_INPUT        = 6'h20;
   localparam logic [5:0] TAG_OUTPUT       = 6'h24;
   localparam logic [5:0] TAG_FEATURE      = 6'h2c;

   // Main kind register codes
   localparam logic [1:0] KIND_INPUT   = 2'd0;
   localparam logic [1:0] KIND_OUTPUT  = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   // Local usage state
   localparam logic [1:0] USAGE_NONE  = 2'd0;
   localparam logic [1:0] USAGE_SHORT = 2'd1;
   localparam logic [1:0] USAGE_FULL  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_MAIN_KIND    = 3'd0;
   localparam logic [2:0] REG_LOGICAL_LOW  = 3'd1;
   localparam logic [2:0] REG_LOGICAL_HIGH = 3'd2;
   localparam logic [2:0] REG_ITEM_FLAGS   = 3'd3;
   localparam logic [2:0] REG_VENDOR_BYTE  = 3'd4;

   // Result kinds
   localparam logic RESULT_MATCH   = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef struct packed {
      logic [1:0]         main_kind;
      logic signed [31:0] logical_low;
      logic signed [31:0] logical_high;
      logic [31:0]        item_flags;
      logic [7:0]         vendor_byte;
   } cfg_type;

   // Parser output: one decoded byte, up to two results
   typedef struct packed {
      logic        match_v;
      logic        sum_v;
      logic [7:0]  report_id;
      logic [31:0] count;
      logic [31:0] bits;
      logic        trunc;
      logic        push_pop;
   } event_type;

   // After the size multiply
   typedef struct packed {
      logic        match_v;
      logic        sum_v;
      logic [7:0]  report_id;
      logic [28:0] bytes;
      logic        trunc;
      logic        push_pop;
   } sized_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  report_number;
      logic [28:0] report_bytes;
      logic [15:0] reports_found;
      logic [28:0] largest_bytes;
      logic        was_truncated;
      logic        saw_push_pop;
      logic        last_of_run;
   } rsp_type;

   // Short item data size; size code 3 means 4 bytes
   function automatic logic [2:0] data_size(input logic [7:0] prefix);
      data_size = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
   endfunction

endpackage

// File: sv/hrdp_parser.sv
`timescale 1ns / 1ps

module hrdp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          descriptor_byte,
   input  logic                final_byte,
   input  hrdp_pkg::cfg_type   cfg,
   output hrdp_pkg::event_type ev_ff
);

   logic [7:0]  prefix_ff, prefix_in;
   logic [8:0]  left_ff, left_in;
   logic [31:0] data_ff, data_in;
   logic        long_ff, long_in;
   logic        stopped_ff, stopped_in;
   logic [15:0] page_ff, page_in;
   logic [31:0] lmin_ff, lmin_in;
   logic [31:0] lmax_ff, lmax_in;
   logic [1:0]  ldef_ff, ldef_in;
   logic [31:0] bits_ff, bits_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  rid_ff, rid_in;
   logic [31:0] usage_ff, usage_in;
   logic [1:0]  ukind_ff, ukind_in;
   logic        pp_ff, pp_in;
   hrdp_pkg::event_type ev_in;

   logic [1:0]  pos;
   logic        done;
   logic        trunc;
   logic        want_hit;
   logic        match;
   logic [7:0]  usage_top;
   logic [31:0] sdata;
   logic [5:0]  tag;

   // Byte decode and item completion
   always_comb begin
      prefix_in  = prefix_ff;
      left_in    = left_ff;
      data_in    = data_ff;
      long_in    = long_ff;
      stopped_in = stopped_ff;
      page_in    = page_ff;
      lmin_in    = lmin_ff;
      lmax_in    = lmax_ff;
      ldef_in    = ldef_ff;
      bits_in    = bits_ff;
      count_in   = count_ff;
      rid_in     = rid_ff;
      usage_in   = usage_ff;
      ukind_in   = ukind_ff;
      pp_in      = pp_ff;
      done       = 1'b0;
      match      = 1'b0;
      want_hit   = 1'b0;
      pos        = 2'(hrdp_pkg::data_size(prefix_ff) - left_ff[2:0]);

      if (left_ff == '0) begin
         prefix_in = descriptor_byte;
         data_in   = '0;
         if (descriptor_byte == hrdp_pkg::LONG_PREFIX) begin
            left_in = 9'd2;
            long_in = 1'b1;
         end else begin
            left_in = 9'(hrdp_pkg::data_size(descriptor_byte));
            done    = (hrdp_pkg::data_size(descriptor_byte) == 3'd0);
         end
      end else if (prefix_ff == hrdp_pkg::LONG_PREFIX && !long_ff) begin
         // skipping long item data
         left_in = left_ff - 9'd1;
      end else begin
         data_in = data_ff | (32'(descriptor_byte) << {pos, 3'b000});
         left_in = left_ff - 9'd1;
         if (left_in == '0) begin
            if (prefix_ff == hrdp_pkg::LONG_PREFIX) begin
               long_in = 1'b0;
               left_in = 9'(data_in[7:0]);
            end else begin
               done = 1'b1;
            end
         end
      end

      // final byte while item bytes are still owed
      trunc = final_byte && (left_in != '0) &&
              !(prefix_in == hrdp_pkg::LONG_PREFIX && !long_in);
      if (trunc) begin
         stopped_in = 1'b1;
      end

      tag = prefix_in[7:2];
      case (prefix_in[1:0])
         2'd1:    sdata = {{24{data_in[7]}}, data_in[7:0]};
         2'd2:    sdata = {{16{data_in[15]}}, data_in[15:0]};
         default: sdata = data_in;
      endcase

      case (cfg.main_kind)
         hrdp_pkg::KIND_INPUT:   want_hit = (tag == hrdp_pkg::TAG_INPUT);
         hrdp_pkg::KIND_OUTPUT:  want_hit = (tag == hrdp_pkg::TAG_OUTPUT);
         hrdp_pkg::KIND_FEATURE: want_hit = (tag == hrdp_pkg::TAG_FEATURE);
         default:                want_hit = 1'b0;
      endcase

      // page supplies the top of the usage unless a full usage was given
      usage_top = (ukind_ff == hrdp_pkg::USAGE_FULL) ? usage_ff[31:24] : page_ff[15:8];

      if (done && !stopped_in) begin
         case (prefix_in[3:2])
            hrdp_pkg::ITEM_GLOBAL: begin
               case (tag)
                  hrdp_pkg::TAG_USAGE_PAGE: page_in = data_in[15:0];
                  hrdp_pkg::TAG_LOGICAL_MIN: begin
                     lmin_in = sdata;
                     ldef_in = ldef_ff | 2'b01;
                  end
                  hrdp_pkg::TAG_LOGICAL_MAX: begin
                     lmax_in = sdata;
                     ldef_in = ldef_ff | 2'b10;
                  end
                  hrdp_pkg::TAG_REPORT_SIZE:  bits_in  = data_in;
                  hrdp_pkg::TAG_REPORT_ID:    rid_in   = data_in[7:0];
                  hrdp_pkg::TAG_REPORT_COUNT: count_in = data_in;
                  hrdp_pkg::TAG_PUSH,
                  hrdp_pkg::TAG_POP:          pp_in    = 1'b1;
                  default: ;
               endcase
            end
            hrdp_pkg::ITEM_LOCAL: begin
               if (tag == hrdp_pkg::TAG_USAGE) begin
                  if (prefix_in[1:0] == 2'd3) begin
                     usage_in = data_in;
                     ukind_in = hrdp_pkg::USAGE_FULL;
                  end else if (ukind_ff == hrdp_pkg::USAGE_FULL) begin
                     usage_in = {usage_ff[31:16], data_in[15:0]};
                  end else begin
                     usage_in = {16'h0000, data_in[15:0]};
                     ukind_in = hrdp_pkg::USAGE_SHORT;
                  end
               end
            end
            hrdp_pkg::ITEM_MAIN: begin
               match = !pp_ff && want_hit && (ldef_ff == 2'b11) &&
                       (lmin_ff == cfg.logical_low) && (lmax_ff == cfg.logical_high) &&
                       (data_in == cfg.item_flags) && (usage_top == cfg.vendor_byte);
               usage_in = '0;
               ukind_in = hrdp_pkg::USAGE_NONE;
            end
            default: ;
         endcase
      end

      ev_in.match_v   = match;
      ev_in.sum_v     = final_byte;
      ev_in.report_id = rid_ff;
      ev_in.count     = count_ff;
      ev_in.bits      = bits_ff;
      ev_in.trunc     = trunc;
      ev_in.push_pop  = pp_in;

      // end of descriptor: back to the reset state
      if (final_byte) begin
         prefix_in  = '0;
         left_in    = '0;
         data_in    = '0;
         long_in    = 1'b0;
         stopped_in = 1'b0;
         page_in    = 16'hffff;
         lmin_in    = '0;
         lmax_in    = '0;
         ldef_in    = '0;
         bits_in    = '0;
         count_in   = '0;
         rid_in     = '0;
         usage_in   = '0;
         ukind_in   = hrdp_pkg::USAGE_NONE;
         pp_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff  <= '0;
         left_ff    <= '0;
         data_ff    <= '0;
         long_ff    <= 1'b0;
         stopped_ff <= 1'b0;
         page_ff    <= 16'hffff;
         lmin_ff    <= '0;
         lmax_ff    <= '0;
         ldef_ff    <= '0;
         bits_ff    <= '0;
         count_ff   <= '0;
         rid_ff     <= '0;
         usage_ff   <= '0;
         ukind_ff   <= hrdp_pkg::USAGE_NONE;
         pp_ff      <= 1'b0;
         ev_ff      <= '0;
      end else if (accept) begin
         prefix_ff  <= prefix_in;
         left_ff    <= left_in;
         data_ff    <= data_in;
         long_ff    <= long_in;
         stopped_ff <= stopped_in;
         page_ff    <= page_in;
         lmin_ff    <= lmin_in;
         lmax_ff    <= lmax_in;
         ldef_ff    <= ldef_in;
         bits_ff    <= bits_in;
         count_ff   <= count_in;
         rid_ff     <= rid_in;
         usage_ff   <= usage_in;
         ukind_ff   <= ukind_in;
         pp_ff      <= pp_in;
         ev_ff      <= ev_in;
      end else begin
         ev_ff.match_v <= 1'b0;
         ev_ff.sum_v   <= 1'b0;
      end
   end

endmodule

// File: sv/hrdp_rsp_fifo.sv
`timescale 1ns / 1ps

module hrdp_rsp_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        wr_count,
   input  hrdp_pkg::rsp_type                 wr_data0,
   input  hrdp_pkg::rsp_type                 wr_data1,
   input  logic                              rd_en,
   output logic                              rd_valid,
   output hrdp_pkg::rsp_type                 rd_data,
   output logic [$clog2(DEPTH+1)-1:0]        level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   hrdp_pkg::rsp_type entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] tail1;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign rd_valid = (level_ff != '0);
   assign rd_data  = entry_ff[head_ff];
   assign level    = level_ff;
   assign pop      = rd_en && rd_valid;
   assign tail1    = ptr_next(tail_ff);

   // up to two writes and one read per cycle
   always_comb begin
      head_in = pop ? ptr_next(head_ff) : head_ff;
      case (wr_count)
         2'd1:    tail_in = tail1;
         2'd2:    tail_in = ptr_next(tail1);
         default: tail_in = tail_ff;
      endcase
      level_in = level_ff + LVL_W'(wr_count) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entry_ff[tail_ff] <= wr_data0;
      end
      if (wr_count == 2'd2) begin
         entry_ff[tail1] <= wr_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

endmodule

// File: sv/hid_report_descriptor_parser_unit.sv
`timescale 1ns / 1ps

// Streaming HID report descriptor parser, one descriptor byte per transfer; a
// byte can be accepted every cycle while req_stall is low. Each byte is decoded
// in the cycle it is accepted; the report size multiply has its own register.
// A byte can cause up to two results (a match and, on the final byte, the
// summary) while the result port moves one per cycle unless stalled, so
// req_stall rises whenever the result queue (RSP_FIFO_DEPTH entries, at least
// six) could not take two results for every result-bearing byte in the
// pipeline plus the next one. With at most one result per byte and no
// rsp_stall the sustained rate is one byte per cycle. The user must write
// match registers through the APB-style port only while the block is idle;
// the block does not enforce this. All parser state returns to reset after the final byte.
module hid_report_descriptor_parser_unit #(
   parameter int RSP_FIFO_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_descriptor_byte,
   input  logic        req_final_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_report_number,
   output logic [28:0] rsp_report_bytes,
   output logic [15:0] rsp_reports_found,
   output logic [28:0] rsp_largest_bytes,
   output logic        rsp_was_truncated,
   output logic        rsp_saw_push_pop,
   output logic        rsp_last_of_run,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LVL_W = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W = LVL_W + 2;

   hrdp_pkg::cfg_type   cfg_ff;
   hrdp_pkg::event_type ev1;
   hrdp_pkg::sized_type ev2_ff;
   hrdp_pkg::rsp_type   match_rsp, sum_rsp, wr_data0;
   logic [31:0]         product;
   logic [15:0]         found_ff, found_in, found_m;
   logic [28:0]         largest_ff, largest_in, largest_m;
   logic [1:0]          wr_count;
   logic [LVL_W-1:0]    fifo_level;
   logic [OCC_W-1:0]    occupancy;
   logic                req_accept;
   logic                csr_write;
   hrdp_pkg::rsp_type   rd_data;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_kind    <= hrdp_pkg::KIND_OUTPUT;
         cfg_ff.logical_low  <= '0;
         cfg_ff.logical_high <= 32'sd255;
         cfg_ff.item_flags   <= '0;
         cfg_ff.vendor_byte  <= 8'hff;
      end else if (csr_write) begin
         case (paddr[4:2])
            hrdp_pkg::REG_MAIN_KIND:    cfg_ff.main_kind    <= pwdata[1:0];
            hrdp_pkg::REG_LOGICAL_LOW:  cfg_ff.logical_low  <= pwdata;
            hrdp_pkg::REG_LOGICAL_HIGH: cfg_ff.logical_high <= pwdata;
            hrdp_pkg::REG_ITEM_FLAGS:   cfg_ff.item_flags   <= pwdata;
            hrdp_pkg::REG_VENDOR_BYTE:  cfg_ff.vendor_byte  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         hrdp_pkg::REG_MAIN_KIND:    prdata = {30'h0, cfg_ff.main_kind};
         hrdp_pkg::REG_LOGICAL_LOW:  prdata = cfg_ff.logical_low;
         hrdp_pkg::REG_LOGICAL_HIGH: prdata = cfg_ff.logical_high;
         hrdp_pkg::REG_ITEM_FLAGS:   prdata = cfg_ff.item_flags;
         hrdp_pkg::REG_VENDOR_BYTE:  prdata = {24'h0, cfg_ff.vendor_byte};
         default:                    prdata = '0;
      endcase
   end

   // Input side: reserve two queue slots per result-bearing byte in flight and two for the next byte
   always_comb begin
      occupancy = OCC_W'(fifo_level) + OCC_W'(2);
      if (ev1.match_v || ev1.sum_v) begin
         occupancy = occupancy + OCC_W'(2);
      end
      if (ev2_ff.match_v || ev2_ff.sum_v) begin
         occupancy = occupancy + OCC_W'(2);
      end
   end

   assign req_stall  = (occupancy > OCC_W'(RSP_FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   hrdp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .descriptor_byte (req_descriptor_byte),
      .final_byte      (req_final_byte),
      .cfg             (cfg_ff),
      .ev_ff           (ev1)
   );

   // Report size multiply
   assign product = 32'(ev1.count * ev1.bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev2_ff <= '0;
      end else begin
         ev2_ff.match_v   <= ev1.match_v;
         ev2_ff.sum_v     <= ev1.sum_v;
         ev2_ff.report_id <= ev1.report_id;
         ev2_ff.bytes     <= product[31:3];
         ev2_ff.trunc     <= ev1.trunc;
         ev2_ff.push_pop  <= ev1.push_pop;
      end
   end

   // Running totals and result assembly
   always_comb begin
      found_m   = found_ff;
      largest_m = largest_ff;
      if (ev2_ff.match_v) begin
         if (found_ff != 16'hffff) begin
            found_m = found_ff + 16'd1;
         end
         if (ev2_ff.bytes > largest_ff) begin
            largest_m = ev2_ff.bytes;
         end
      end
      found_in   = ev2_ff.sum_v ? '0 : found_m;
      largest_in = ev2_ff.sum_v ? '0 : largest_m;

      match_rsp.result_kind   = hrdp_pkg::RESULT_MATCH;
      match_rsp.report_number = ev2_ff.report_id;
      match_rsp.report_bytes  = ev2_ff.bytes;
      match_rsp.reports_found = found_m;
      match_rsp.largest_bytes = largest_m;
      match_rsp.was_truncated = 1'b0;
      match_rsp.saw_push_pop  = 1'b0;
      match_rsp.last_of_run   = !ev2_ff.sum_v;

      sum_rsp.result_kind   = hrdp_pkg::RESULT_SUMMARY;
      sum_rsp.report_number = '0;
      sum_rsp.report_bytes  = '0;
      sum_rsp.reports_found = found_m;
      sum_rsp.largest_bytes = largest_m;
      sum_rsp.was_truncated = ev2_ff.trunc;
      sum_rsp.saw_push_pop  = ev2_ff.push_pop;
      sum_rsp.last_of_run   = 1'b1;

      wr_data0 = ev2_ff.match_v ? match_rsp : sum_rsp;
      wr_count = 2'(ev2_ff.match_v) + 2'(ev2_ff.sum_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= '0;
         largest_ff <= '0;
      end else begin
         found_ff   <= found_in;
         largest_ff <= largest_in;
      end
   end

   hrdp_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_data0 (wr_data0),
      .wr_data1 (sum_rsp),
      .rd_en    (!rsp_stall),
      .rd_valid (rsp_valid),
      .rd_data  (rd_data),
      .level    (fifo_level)
   );

   assign rsp_result_kind   = rd_data.result_kind;
   assign rsp_report_number = rd_data.report_number;
   assign rsp_report_bytes  = rd_data.report_bytes;
   assign rsp_reports_found = rd_data.reports_found;
   assign rsp_largest_bytes = rd_data.largest_bytes;
   assign rsp_was_truncated = rd_data.was_truncated;
   assign rsp_saw_push_pop  = rd_data.saw_push_pop;
   assign rsp_last_of_run   = rd_data.last_of_run;

   // Checks
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (OCC_W'(fifo_level) + OCC_W'(wr_count)) <= OCC_W'(RSP_FIFO_DEPTH))
      else $error("result queue overflow");

   a_totals_cleared: assert property (@(posedge clock) disable iff (reset)
      ev2_ff.sum_v |=> (found_ff == '0) && (largest_ff == '0))
      else $error("running totals not cleared after summary");

   a_summary_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == hrdp_pkg::RESULT_SUMMARY) |-> rsp_last_of_run)
      else $error("summary transfer not marked last");

   a_match_after_mult: assert property (@(posedge clock) disable iff (reset)
      ev1.match_v |=> ev2_ff.match_v && (ev2_ff.bytes == $past(product[31:3])))
      else $error("match lost in size stage");

endmodule

// File: tb/tb_hid_report_descriptor_parser_unit.sv
`timescale 1ns / 1ps

module tb_hid_report_descriptor_parser_unit;
   import hrdp_pkg::*;

   // Kind code outside the legal range: no main item ever matches
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int BYTES_PER_SETTING = 300;
   localparam int SETTINGS_COUNT = 6;

   // Expected results that can be read straight off the descriptor
   localparam rsp_type NOTHING = '0;
   localparam rsp_type SUMMARY_CLEAN = '{result_kind: RESULT_SUMMARY, report_number: 8'd0,
      report_bytes: 29'd0, reports_found: 16'd0, largest_bytes: 29'd0,
      was_truncated: 1'b0, saw_push_pop: 1'b0, last_of_run: 1'b1};
   localparam rsp_type SUMMARY_TRUNC = '{result_kind: RESULT_SUMMARY, report_number: 8'd0,
      report_bytes: 29'd0, reports_found: 16'd0, largest_bytes: 29'd0,
      was_truncated: 1'b1, saw_push_pop: 1'b0, last_of_run: 1'b1};
   localparam rsp_type MATCH_FIRST = '{result_kind: RESULT_MATCH, report_number: 8'd7,
      report_bytes: 29'd64, reports_found: 16'd1, largest_bytes: 29'd64,
      was_truncated: 1'b0, saw_push_pop: 1'b0, last_of_run: 1'b1};

   typedef struct packed {
      logic [7:0] b;
      logic       fin;
      logic       typed;
      rsp_type    want;
   } stim_row;

   // Directed descriptor bytes, walked in order under the reset settings
   localparam int DIRECTED_LEN = 24;
   localparam stim_row DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
      '{8'h00, 1'b1, 1'b1, SUMMARY_CLEAN},  // lone main item as the whole descriptor
      '{8'h06, 1'b0, 1'b0, NOTHING},        // usage page 0xff00
      '{8'h00, 1'b0, 1'b0, NOTHING},
      '{8'hff, 1'b0, 1'b0, NOTHING},
      '{8'h15, 1'b0, 1'b0, NOTHING},        // logical minimum 0
      '{8'h00, 1'b0, 1'b0, NOTHING},
      '{8'h26, 1'b0, 1'b0, NOTHING},        // logical maximum 255, two bytes
      '{8'hff, 1'b0, 1'b0, NOTHING},
      '{8'h00, 1'b0, 1'b0, NOTHING},
      '{8'h75, 1'b0, 1'b0, NOTHING},        // report size 8
      '{8'h08, 1'b0, 1'b0, NOTHING},
      '{8'h95, 1'b0, 1'b0, NOTHING},        // report count 64
      '{8'h40, 1'b0, 1'b0, NOTHING},
      '{8'h85, 1'b0, 1'b0, NOTHING},        // report id 7
      '{8'h07, 1'b0, 1'b0, NOTHING},
      '{8'h91, 1'b0, 1'b0, NOTHING},        // output, flags 0
      '{8'h00, 1'b0, 1'b1, MATCH_FIRST},
      '{8'hfe, 1'b0, 1'b0, NOTHING},        // long item, one data byte skipped
      '{8'h01, 1'b0, 1'b0, NOTHING},
      '{8'h30, 1'b0, 1'b0, NOTHING},
      '{8'h55, 1'b0, 1'b0, NOTHING},
      '{8'h91, 1'b0, 1'b0, NOTHING},        // match on the final byte, then summary
      '{8'h00, 1'b1, 1'b0, NOTHING},
      '{8'hff, 1'b1, 1'b1, SUMMARY_TRUNC}   // 4-byte prefix as final byte
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_descriptor_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_report_number;
   logic [28:0] rsp_report_bytes;
   logic [15:0] rsp_reports_found;
   logic [28:0] rsp_largest_bytes;
   logic        rsp_was_truncated;
   logic        rsp_saw_push_pop;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   hid_report_descriptor_parser_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_descriptor_byte(req_descriptor_byte), .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_report_number(rsp_report_number),
      .rsp_report_bytes(rsp_report_bytes), .rsp_reports_found(rsp_reports_found),
      .rsp_largest_bytes(rsp_largest_bytes), .rsp_was_truncated(rsp_was_truncated),
      .rsp_saw_push_pop(rsp_saw_push_pop), .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Checker bookkeeping
   rsp_type pending_reports[$];
   rsp_type step_results[$];
   rsp_type oldest;
   int error_count = 0;
   int results_checked = 0;
   int matches_seen = 0;
   int summaries_seen = 0;
   int cut_seen = 0;
   int bytes_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Shadow of the match registers and of the parser state
   cfg_type     match_cfg;
   logic [7:0]  ps_prefix;
   logic [8:0]  ps_left;
   logic [31:0] ps_data;
   logic        ps_long_hdr;
   logic        ps_stopped;
   logic [15:0] ps_page;
   logic [31:0] ps_lmin;
   logic [31:0] ps_lmax;
   logic [1:0]  ps_ldef;
   logic [31:0] ps_size;
   logic [31:0] ps_count;
   logic [7:0]  ps_id;
   logic [31:0] ps_usage;
   logic [1:0]  ps_usage_kind;
   logic        ps_pushpop;
   logic [15:0] ps_found;
   logic [28:0] ps_largest;

   logic [7:0]  desc_bytes[$];

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 60)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_error($sformatf("result %0d %s: got %0h, want %0h",
                              results_checked, name, got, want));
   endtask

   function automatic logic [2:0] item_len(input logic [7:0] p);
      return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
   endfunction

   function automatic logic [31:0] widen_signed(input logic [7:0] p, input logic [31:0] d);
      case (item_len(p))
         3'd1: return {{24{d[7]}}, d[7:0]};
         3'd2: return {{16{d[15]}}, d[15:0]};
         default: return d;
      endcase
   endfunction

   function automatic logic [5:0] kind_tag(input logic [1:0] k);
      case (k)
         KIND_INPUT:   return TAG_INPUT;
         KIND_FEATURE: return TAG_FEATURE;
         default:      return TAG_OUTPUT;
      endcase
   endfunction

   function automatic void clear_parse_state();
      ps_prefix = '0; ps_left = '0; ps_data = '0; ps_long_hdr = 1'b0; ps_stopped = 1'b0;
      ps_page = 16'hffff; ps_lmin = '0; ps_lmax = '0; ps_ldef = '0;
      ps_size = '0; ps_count = '0; ps_id = '0; ps_usage = '0; ps_usage_kind = USAGE_NONE;
      ps_pushpop = 1'b0; ps_found = '0; ps_largest = '0;
   endfunction

   // Act on a completed short item; a matching main item adds a report
   function automatic void apply_item(input logic fin);
      logic [7:0]  p;
      logic [31:0] d;
      logic [31:0] usage;
      logic [31:0] prod;
      logic [5:0]  tag;
      rsp_type     r;
      p = ps_prefix;
      d = ps_data;
      tag = p[7:2];
      case (p[3:2])
         ITEM_GLOBAL: begin
            case (tag)
               TAG_USAGE_PAGE:   ps_page = d[15:0];
               TAG_LOGICAL_MIN: begin
                  ps_lmin = widen_signed(p, d);
                  ps_ldef[0] = 1'b1;
               end
               TAG_LOGICAL_MAX: begin
                  ps_lmax = widen_signed(p, d);
                  ps_ldef[1] = 1'b1;
               end
               TAG_REPORT_SIZE:  ps_size = d;
               TAG_REPORT_ID:    ps_id = d[7:0];
               TAG_REPORT_COUNT: ps_count = d;
               TAG_PUSH, TAG_POP: ps_pushpop = 1'b1;
               default: ;
            endcase
         end
         ITEM_LOCAL: begin
            if (tag == TAG_USAGE) begin
               if (item_len(p) == 3'd4) begin
                  ps_usage = d;
                  ps_usage_kind = USAGE_FULL;
               end else if (ps_usage_kind == USAGE_FULL) begin
                  ps_usage[15:0] = d[15:0];
               end else begin
                  ps_usage = {16'h0000, d[15:0]};
                  ps_usage_kind = USAGE_SHORT;
               end
            end
         end
         ITEM_MAIN: begin
            case (ps_usage_kind)
               USAGE_FULL:  usage = ps_usage;
               USAGE_SHORT: usage = {ps_page, ps_usage[15:0]};
               default:     usage = {ps_page, 16'hffff};
            endcase
            if (!ps_pushpop && match_cfg.main_kind != KIND_NONE &&
                tag == kind_tag(match_cfg.main_kind) && ps_ldef == 2'b11 &&
                ps_lmin == match_cfg.logical_low && ps_lmax == match_cfg.logical_high &&
                d == match_cfg.item_flags && usage[31:24] == match_cfg.vendor_byte) begin
               prod = ps_count * ps_size;
               if (ps_found != 16'hffff)
                  ps_found++;
               if (prod[31:3] > ps_largest)
                  ps_largest = prod[31:3];
               r = '{result_kind: RESULT_MATCH, report_number: ps_id,
                     report_bytes: prod[31:3], reports_found: ps_found,
                     largest_bytes: ps_largest, was_truncated: 1'b0,
                     saw_push_pop: 1'b0, last_of_run: !fin};
               step_results.push_back(r);
            end
            ps_usage = '0;
            ps_usage_kind = USAGE_NONE;
         end
         default: ;
      endcase
   endfunction

   // Predict the results of one accepted descriptor byte into step_results
   function automatic void scan_byte(input logic [7:0] b, input logic fin);
      logic [2:0] pos;
      logic       done;
      logic       trunc;
      rsp_type    r;
      step_results.delete();
      done = 1'b0;
      if (ps_left == 0) begin
         ps_prefix = b;
         ps_data = '0;
         if (b == LONG_PREFIX) begin
            ps_left = 9'd2;
            ps_long_hdr = 1'b1;
         end else begin
            ps_left = {6'd0, item_len(b)};
            done = (ps_left == 0);
         end
      end else if (ps_prefix == LONG_PREFIX && !ps_long_hdr) begin
         ps_left--;
      end else begin
         pos = item_len(ps_prefix) - ps_left[2:0];
         ps_data = ps_data | (32'(b) << (8 * pos[1:0]));
         ps_left--;
         if (ps_left == 0) begin
            if (ps_prefix == LONG_PREFIX) begin
               ps_long_hdr = 1'b0;
               ps_left = {1'b0, ps_data[7:0]};
            end else begin
               done = 1'b1;
            end
         end
      end
      // Data still owed at the end; skipped long item data does not count
      trunc = fin && ps_left != 0 && !(ps_prefix == LONG_PREFIX && !ps_long_hdr);
      if (trunc)
         ps_stopped = 1'b1;
      if (done && !ps_stopped)
         apply_item(fin);
      if (fin) begin
         r = '{result_kind: RESULT_SUMMARY, report_number: 8'd0, report_bytes: 29'd0,
               reports_found: ps_found, largest_bytes: ps_largest, was_truncated: trunc,
               saw_push_pop: ps_pushpop, last_of_run: 1'b1};
         step_results.push_back(r);
         clear_parse_state();
      end
   endfunction

   // One input transfer; expectations are queued at acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input rsp_type typed_want);
      req_valid <= 1'b1;
      req_descriptor_byte <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      scan_byte(b, fin);
      if (typed)
         pending_reports.push_back(typed_want);
      else
         foreach (step_results[i]) pending_reports.push_back(step_results[i]);
      bytes_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // Hold off until every expected result is out, plus the pipeline depth
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_MAIN_KIND:    match_cfg.main_kind = v[1:0];
         REG_LOGICAL_LOW:  match_cfg.logical_low = v;
         REG_LOGICAL_HIGH: match_cfg.logical_high = v;
         REG_ITEM_FLAGS:   match_cfg.item_flags = v;
         REG_VENDOR_BYTE:  match_cfg.vendor_byte = v[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] kind, input logic [31:0] low,
                            input logic [31:0] high, input logic [31:0] flags,
                            input logic [7:0] vendor);
      write_reg(REG_MAIN_KIND, {30'd0, kind});
      write_reg(REG_LOGICAL_LOW, low);
      write_reg(REG_LOGICAL_HIGH, high);
      write_reg(REG_ITEM_FLAGS, flags);
      write_reg(REG_VENDOR_BYTE, {24'd0, vendor});
   endtask

   // Descriptor building
   function automatic int fit_unsigned(input logic [31:0] v);
      if (v == 0) return 0;
      if (v < 256) return 1;
      if (v < 65536) return 2;
      return 4;
   endfunction

   function automatic int fit_signed(input logic [31:0] v);
      if ($signed(v) >= -128 && $signed(v) <= 127) return 1;
      if ($signed(v) >= -32768 && $signed(v) <= 32767) return 2;
      return 4;
   endfunction

   function automatic int any_len();
      case ($urandom_range(3))
         0: return 0;
         1: return 1;
         2: return 2;
         default: return 4;
      endcase
   endfunction

   function automatic void put_item(input logic [5:0] tag, input logic [31:0] v, input int n);
      desc_bytes.push_back({tag, (n == 4) ? 2'd3 : 2'(n)});
      for (int i = 0; i < n; i++)
         desc_bytes.push_back(v[8*i +: 8]);
   endfunction

   // Mostly well-formed descriptors steered toward the match settings
   function automatic void build_descriptor();
      int          items;
      int          sel;
      int          n;
      logic [31:0] v;
      logic [7:0]  p;
      logic [5:0]  tag;
      desc_bytes.delete();
      if ($urandom_range(99) < 15) begin
         // raw noise
         repeat ($urandom_range(1, 16)) desc_bytes.push_back(8'($urandom));
         return;
      end
      items = $urandom_range(2, 14);
      repeat (items) begin
         sel = $urandom_range(99);
         if (sel < 10) begin
            v = ($urandom_range(3) != 0) ? {16'd0, match_cfg.vendor_byte, 8'($urandom)}
                                         : $urandom;
            put_item(TAG_USAGE_PAGE, v, ($urandom_range(3) != 0) ? 2 : any_len());
         end else if (sel < 30) begin
            tag = (sel < 20) ? TAG_LOGICAL_MIN : TAG_LOGICAL_MAX;
            if ($urandom_range(3) != 0)
               v = (sel < 20) ? match_cfg.logical_low : match_cfg.logical_high;
            else
               v = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(0, 600) - 300);
            n = ($urandom_range(1) != 0) ? fit_signed(v) : 4;
            if (v == 0 && $urandom_range(2) == 0)
               n = 0;
            put_item(tag, v, n);
         end else if (sel < 46) begin
            tag = (sel < 38) ? TAG_REPORT_SIZE : TAG_REPORT_COUNT;
            v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 40);
            n = ($urandom_range(3) != 0) ? fit_unsigned(v) : 4;
            put_item(tag, v, n);
         end else if (sel < 52) begin
            put_item(TAG_REPORT_ID, $urandom, ($urandom_range(3) != 0) ? 1 : any_len());
         end else if (sel < 62) begin
            n = any_len();
            v = $urandom;
            if (n == 4 && $urandom_range(3) != 0)
               v[31:24] = match_cfg.vendor_byte;
            put_item(TAG_USAGE, v, n);
         end else if (sel < 85) begin
            if ($urandom_range(9) < 7)
               tag = kind_tag(match_cfg.main_kind);
            else
               tag = kind_tag(2'($urandom_range(0, 2)));
            v = ($urandom_range(3) != 0) ? match_cfg.item_flags : $urandom_range(0, 3);
            n = ($urandom_range(3) != 0) ? fit_unsigned(v) : 4;
            put_item(tag, v, n);
         end else if (sel < 88) begin
            put_item(($urandom_range(1) != 0) ? TAG_PUSH : TAG_POP, $urandom,
                     $urandom_range(0, 1));
         end else if (sel < 93) begin
            n = $urandom_range(0, 4);
            desc_bytes.push_back(LONG_PREFIX);
            desc_bytes.push_back(8'(n));
            desc_bytes.push_back(8'($urandom));
            repeat (n) desc_bytes.push_back(8'($urandom));
         end else begin
            // any prefix, with random data of its own size
            p = 8'($urandom);
            desc_bytes.push_back(p);
            repeat (item_len(p)) desc_bytes.push_back(8'($urandom));
         end
      end
      // cut the tail now and then so the last item may overrun the end
      if ($urandom_range(99) < 15 && desc_bytes.size() > 1)
         repeat ($urandom_range(1, (desc_bytes.size() > 4) ? 4 : desc_bytes.size() - 1))
            void'(desc_bytes.pop_back());
   endfunction

   task automatic send_descriptor();
      int last;
      build_descriptor();
      last = desc_bytes.size() - 1;
      for (int i = 0; i <= last; i++)
         send_byte(desc_bytes[i], i == last, 1'b0, NOTHING);
   endtask

   // Result side: check each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            note_error("result transfer with nothing expected");
         end else begin
            oldest = pending_reports.pop_front();
            check_field("result_kind", rsp_result_kind, oldest.result_kind);
            check_field("report_number", rsp_report_number, oldest.report_number);
            check_field("report_bytes", rsp_report_bytes, oldest.report_bytes);
            check_field("reports_found", rsp_reports_found, oldest.reports_found);
            check_field("largest_bytes", rsp_largest_bytes, oldest.largest_bytes);
            check_field("was_truncated", rsp_was_truncated, oldest.was_truncated);
            check_field("saw_push_pop", rsp_saw_push_pop, oldest.saw_push_pop);
            check_field("last_of_run", rsp_last_of_run, oldest.last_of_run);
            results_checked++;
            if (oldest.result_kind == RESULT_MATCH)
               matches_seen++;
            else
               summaries_seen++;
            if (oldest.result_kind == RESULT_SUMMARY && oldest.was_truncated)
               cut_seen++;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Stimulus
   initial begin
      int phase;
      match_cfg = '{main_kind: KIND_OUTPUT, logical_low: 32'sd0, logical_high: 32'sd255,
                    item_flags: 32'd0, vendor_byte: 8'hff};
      clear_parse_state();
      send_idle_pct = 28;
      recv_idle_pct = 85;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_LEN; i++)
         send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
      drain();

      for (phase = 0; phase < SETTINGS_COUNT; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 28; recv_idle_pct = 85; end
            1: begin send_idle_pct = 85; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: configure(KIND_INPUT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 8'h00);
            1: configure(KIND_FEATURE, 32'hffff_ffff, 32'd1, 32'd2, 8'hff);
            2: configure(KIND_NONE, 32'd0, 32'd255, 32'd0, 8'hff);
            3: configure(KIND_OUTPUT, 32'd0, 32'd255, 32'd0, 8'($urandom));
            default: configure(2'($urandom_range(0, 2)), 32'($urandom_range(0, 40) - 20),
                               32'($urandom_range(0, 300)),
                               ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 255),
                               8'($urandom));
         endcase
         while (bytes_sent < DIRECTED_LEN + (phase + 1) * BYTES_PER_SETTING) begin
            if ($urandom_range(24) == 0)
               drain();
            send_descriptor();
         end
         drain();
      end

      $display("tb: %0d descriptor bytes under %0d match settings, %0d results checked",
               bytes_sent, SETTINGS_COUNT + 1, results_checked);
      $display("tb: %0d matching reports, %0d descriptor ends, %0d of them cut short",
               matches_seen, summaries_seen, cut_seen);
      if (error_count == 0 && pending_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
